@@ src/command_value_frame_parser_top_macros.svh @@
// ----------------------------------------------------------------------------
// Command/value frame parser assertion macros
// Shorthand for the concurrent checks on the top-level ports.
// ----------------------------------------------------------------------------
`ifndef COMMAND_VALUE_FRAME_PARSER_TOP_MACROS_SVH
`define COMMAND_VALUE_FRAME_PARSER_TOP_MACROS_SVH

// Checked only while the block is out of reset.
`define CVFP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("cvfp check failed");

// Checked at every edge, reset included.
`define CVFP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("cvfp check failed");

`endif

@@ src/cvfp_pkg.sv @@
// ----------------------------------------------------------------------------
// cvfp_pkg
// Shared character codes and the result type of the frame parser.
// ----------------------------------------------------------------------------
package cvfp_pkg;

    localparam logic [7:0] CH_START = 8'h3E;  // '>'
    localparam logic [7:0] CH_END   = 8'h3C;  // '<'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_G     = 8'h47;

    typedef struct packed {
        logic       frame_done;
        logic [7:0] frame_value;
        logic [7:0] command_letter;
    } cvfp_result_t;

endpackage

@@ src/cvfp_parser.sv @@
// ----------------------------------------------------------------------------
// cvfp_parser
// Frame state machine: consumes one byte per accepted beat and produces the
// result for that byte combinationally from the current state.
// ----------------------------------------------------------------------------
module cvfp_parser
    import cvfp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         byte_accept,
    input  logic [7:0]   rx_byte,
    output cvfp_result_t result
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LETTER = 3'd1,
        PH_COMMA1 = 3'd2,
        PH_DIGITS = 3'd3,
        PH_CHKSUM = 3'd4,
        PH_CLOSE  = 3'd5
    } phase_t;

    phase_t     phase_reg,  phase_next;
    logic [7:0] xor_reg,    xor_next;
    logic [7:0] value_reg,  value_next;
    logic [7:0] letter_reg, letter_next;
    logic       done;
    logic       is_letter;
    logic       is_digit;
    logic [7:0] value_step;

    assign is_letter = (rx_byte == CH_V) || (rx_byte == CH_D) ||
                       (rx_byte == CH_T) || (rx_byte == CH_G);
    assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    // value * 10 + digit, modulo 256; the digit is the low nibble of its code.
    assign value_step = (value_reg << 3) + (value_reg << 1) + {4'd0, rx_byte[3:0]};

    always_comb begin
        phase_next  = phase_reg;
        xor_next    = xor_reg;
        value_next  = value_reg;
        letter_next = letter_reg;
        done        = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (rx_byte == CH_START) begin
                    xor_next   = rx_byte;
                    phase_next = PH_LETTER;
                end
            end
            PH_LETTER: begin
                if (is_letter) begin
                    letter_next = rx_byte;
                    xor_next    = xor_reg ^ rx_byte;
                    phase_next  = PH_COMMA1;
                end else begin
                    phase_next  = PH_IDLE;
                    xor_next    = '0;
                    letter_next = '0;
                end
            end
            PH_COMMA1: begin
                if (rx_byte == CH_COMMA) begin
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = PH_DIGITS;
                end else begin
                    phase_next  = PH_IDLE;
                    xor_next    = '0;
                    letter_next = '0;
                end
            end
            PH_DIGITS: begin
                if (rx_byte == CH_COMMA) begin
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = PH_CHKSUM;
                end else if (is_digit) begin
                    value_next = value_step;
                    xor_next   = xor_reg ^ rx_byte;
                end else begin
                    phase_next  = PH_IDLE;
                    xor_next    = '0;
                    value_next  = '0;
                    letter_next = '0;
                end
            end
            PH_CHKSUM: begin
                if (rx_byte == xor_reg) begin
                    phase_next = PH_CLOSE;
                end else begin
                    phase_next  = PH_IDLE;
                    xor_next    = '0;
                    value_next  = '0;
                    letter_next = '0;
                end
            end
            PH_CLOSE: begin
                done       = (rx_byte == CH_END);
                phase_next = PH_IDLE;
                xor_next   = '0;
                value_next = '0;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        result.frame_done     = done;
        result.frame_value    = done ? value_reg : 8'd0;
        result.command_letter = letter_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            xor_reg    <= '0;
            value_reg  <= '0;
            letter_reg <= '0;
        end else if (byte_accept) begin
            phase_reg  <= phase_next;
            xor_reg    <= xor_next;
            value_reg  <= value_next;
            letter_reg <= letter_next;
        end
    end

endmodule

@@ src/cvfp_out_reg.sv @@
// ----------------------------------------------------------------------------
// cvfp_out_reg
// Result register of the parser; holds a beat until the sink takes it.
// ----------------------------------------------------------------------------
module cvfp_out_reg
    import cvfp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  cvfp_result_t load_data,
    input  logic         take,
    output logic         out_valid,
    output cvfp_result_t out_data
);

    logic         valid_reg, valid_next;
    cvfp_result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ src/command_value_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// command_value_frame_parser_top
// Recognizes '>' letter ',' digits ',' checksum '<' frames, one byte per beat.
//
//   Channel | Dir | Beat contents
//   --------+-----+--------------------------------------------------------
//   s_      | in  | tdata[7:0] rx_byte
//   m_      | out | tuser frame_done; tdata[7:0] frame_value,
//           |     | tdata[15:8] command_letter
//
// Every input beat yields exactly one output beat, registered and shown in the cycle after it is accepted.
// Throughput is one byte per clock while the sink keeps m_tready high; the parser state updates in the accept
// cycle and the result lands in a single output register.
// s_tready is high while the output register is empty or being drained.
// aresetn (synchronous, active low) returns the parser to idle with all
// state cleared and empties the output register.
// ----------------------------------------------------------------------------
module command_value_frame_parser_top
    import cvfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] frame_value, [15:8] command_letter
    output logic        m_tuser    // [0] frame_done
);

    logic         in_accept;
    cvfp_result_t step_result;
    cvfp_result_t out_result;

    assign s_tready  = !m_tvalid || m_tready;
    assign in_accept = s_tvalid && s_tready;

    cvfp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (in_accept),
        .rx_byte     (s_tdata),
        .result      (step_result)
    );

    cvfp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (in_accept),
        .load_data (step_result),
        .take      (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_result)
    );

    assign m_tdata = {out_result.command_letter, out_result.frame_value};
    assign m_tuser = out_result.frame_done;

endmodule

@@ src/cvfp_checker.sv @@
// ----------------------------------------------------------------------------
// cvfp_checker
// Port-level checks on the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "command_value_frame_parser_top_macros.svh"

module cvfp_checker
    import cvfp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    logic        done_letter_ok;
    logic        in_seen;
    logic        out_stall;
    logic [16:0] out_beat;

    assign done_letter_ok = (m_tdata[15:8] == CH_V) || (m_tdata[15:8] == CH_D) ||
                            (m_tdata[15:8] == CH_T) || (m_tdata[15:8] == CH_G);
    assign in_seen   = s_tvalid && s_tready && (s_tdata == s_tdata);
    assign out_stall = m_tvalid && !m_tready;
    assign out_beat  = {m_tuser, m_tdata};

    // A stalled output beat keeps its contents.
    `CVFP_ASSERT(a_out_hold, aclk, aresetn, out_stall |=> m_tvalid && $stable(out_beat))
    // A completed frame always carries one of the four command letters.
    `CVFP_ASSERT(a_done_letter, aclk, aresetn, m_tvalid && m_tuser |-> done_letter_ok)
    // Without a completed frame the value field reads zero.
    `CVFP_ASSERT(a_idle_value, aclk, aresetn, m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
    // Each accepted byte shows up as an output beat in the next cycle.
    `CVFP_ASSERT(a_one_per_byte, aclk, aresetn, in_seen |=> m_tvalid)
    // Reset empties the output register.
    `CVFP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind command_value_frame_parser_top cvfp_checker u_cvfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
